// File: rtl/dual_quadrature_decoder_velocity_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual quadrature decoder
// Shared property wrappers; clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_DECODER_VELOCITY_DEFINES_SVH
`define DUAL_QUADRATURE_DECODER_VELOCITY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define QDV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdv assertion failed");

// antecedent implies consequent in the following cycle
`define QDV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdv assertion failed");

`else

`define QDV_ASSERT_SAME(label, ante, cons)
`define QDV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/qdv_pkg.sv
// ---------------------------------------------------------------------------
// qdv_pkg
// Types, constants and helpers for the dual quadrature decoder.
// ---------------------------------------------------------------------------
package qdv_pkg;

  // width of the internal position counters
  localparam int COUNT_WIDTH = 16;
  localparam int PHASE_W     = 2;
  localparam int OUT_W       = 16;
  localparam int TICK_W      = 8;
  localparam int TABLE_W     = 32;

  localparam logic [TICK_W-1:0]  TICKS_RESET = 8'd20;
  localparam logic [TABLE_W-1:0] TABLE_RESET = 32'h1CC1_4334;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_TICKS_PER_WINDOW = 1'b0,
    REG_TRANSITION_TABLE = 1'b1
  } qdv_reg_t;

  // item function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_PIN  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [PHASE_W-1:0] right_phases;
    logic [PHASE_W-1:0] left_phases;
  } qdv_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_position;
    logic signed [OUT_W-1:0] left_position;
    logic signed [OUT_W-1:0] right_speed;
    logic signed [OUT_W-1:0] left_speed;
    logic                    window_done;
  } qdv_out_t;

  // per-item lane control, already qualified by the input handshake
  typedef struct packed {
    logic pin;    // pin-change word accepted
    logic close;  // tick word accepted that ends a window
  } qdv_lane_ctl_t;

  // signed step from the packed transition table
  function automatic logic [COUNT_WIDTH-1:0] qdv_step(
    logic [TABLE_W-1:0] tbl,
    logic [PHASE_W-1:0] old_ph,
    logic [PHASE_W-1:0] new_ph
  );
    logic [3:0] idx;
    logic [1:0] code;
    idx  = {old_ph, new_ph};
    code = tbl[{idx, 1'b0} +: 2];
    return {{(COUNT_WIDTH-2){code[1]}}, code};
  endfunction

  // low 16 bits of a counter, zero extended when the counter is narrower
  function automatic logic [OUT_W-1:0] qdv_low(logic [COUNT_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/qdv_window.sv
// ---------------------------------------------------------------------------
// qdv_window
// Tick counter for the velocity window; decides which accepted word closes
// a window and fans the result out to both lanes as one control word.
// ---------------------------------------------------------------------------
module qdv_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       func,
  input  logic [qdv_pkg::TICK_W-1:0] ticks_per_window,
  output qdv_pkg::qdv_lane_ctl_t     ctl
);
  import qdv_pkg::*;

  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  logic [TICK_W:0]   tick_inc;
  logic              is_tick;

  // next tick count, one bit wider so 255 + 1 does not wrap
  always_comb begin
    is_tick         = accept && (func == FUNC_TICK);
    tick_inc        = {1'b0, tick_count} + {{TICK_W{1'b0}}, 1'b1};
    ctl.pin         = accept && (func == FUNC_PIN);
    ctl.close       = is_tick && (tick_inc >= {1'b0, ticks_per_window});
    tick_count_next = tick_count;
    if (ctl.close) begin
      tick_count_next = '0;
    end else if (is_tick) begin
      tick_count_next = tick_inc[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else begin
      tick_count <= tick_count_next;
    end
  end

endmodule

// File: rtl/qdv_lane.sv
// ---------------------------------------------------------------------------
// qdv_lane
// One encoder channel: table step on a pin change, window difference on a
// window close. Gives the post-word position and speed combinationally.
// ---------------------------------------------------------------------------
module qdv_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  qdv_pkg::qdv_lane_ctl_t      ctl,
  input  logic [qdv_pkg::TABLE_W-1:0] transition_table,
  input  logic [qdv_pkg::PHASE_W-1:0] phases,
  output logic [qdv_pkg::OUT_W-1:0]   position,
  output logic [qdv_pkg::OUT_W-1:0]   speed
);
  import qdv_pkg::*;

  logic [PHASE_W-1:0]     last_phase;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] window_start;
  logic [COUNT_WIDTH-1:0] rate;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] rate_next;

  // step and window difference
  always_comb begin
    count_next = count;
    rate_next  = rate;
    if (ctl.pin) begin
      count_next = count + qdv_step(transition_table, last_phase, phases);
    end
    if (ctl.close) begin
      rate_next = count - window_start;
    end
    position = qdv_low(count_next);
    speed    = qdv_low(rate_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase   <= '0;
      count        <= '0;
      window_start <= '0;
      rate         <= '0;
    end else begin
      if (ctl.pin) begin
        last_phase <= phases;
        count      <= count_next;
      end
      if (ctl.close) begin
        rate         <= rate_next;
        window_start <= count;
      end
    end
  end

endmodule

// File: rtl/dual_quadrature_decoder_velocity.sv
// ---------------------------------------------------------------------------
// dual_quadrature_decoder_velocity
// Two-channel quadrature decoder with windowed velocity measurement.
// ---------------------------------------------------------------------------
// Every accepted word (pin change or timer tick) gives exactly one result
// word. A word is processed in the cycle it is accepted: both channel lanes
// run side by side and their outputs are merged into the result, so one
// word per clock is sustained while out_stall is low. The output side holds
// two words (output register plus skid register); in_stall rises only when
// both are full, so a word waiting on the output does not hold up the next
// one. Write the configuration registers only while no word is in flight.
// ---------------------------------------------------------------------------
`include "dual_quadrature_decoder_velocity_defines.svh"

module dual_quadrature_decoder_velocity (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qdv_pkg::qdv_in_t            in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qdv_pkg::qdv_out_t           out_word,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [qdv_pkg::TABLE_W-1:0] cfg_data
);
  import qdv_pkg::*;

  logic [TICK_W-1:0]  ticks_per_window;
  logic [TABLE_W-1:0] transition_table;
  qdv_lane_ctl_t      win_ctl;
  qdv_out_t           result;
  qdv_out_t           skid_word;
  logic               skid_valid;
  logic               in_acc;
  logic               out_take;
  logic               out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_window <= TICKS_RESET;
      transition_table <= TABLE_RESET;
    end else if (cfg_we) begin
      unique case (qdv_reg_t'(cfg_index))
        REG_TICKS_PER_WINDOW: ticks_per_window <= cfg_data[TICK_W-1:0];
        REG_TRANSITION_TABLE: transition_table <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;
  assign out_free = out_take || !out_valid;

  qdv_window u_window (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_acc),
    .func             (in_word.func),
    .ticks_per_window (ticks_per_window),
    .ctl              (win_ctl)
  );

  qdv_lane u_right (
    .clk              (clk),
    .rst              (rst),
    .ctl              (win_ctl),
    .transition_table (transition_table),
    .phases           (in_word.right_phases),
    .position         (result.right_position),
    .speed            (result.right_speed)
  );

  qdv_lane u_left (
    .clk              (clk),
    .rst              (rst),
    .ctl              (win_ctl),
    .transition_table (transition_table),
    .phases           (in_word.left_phases),
    .position         (result.left_position),
    .speed            (result.left_speed)
  );

  // merge stage flag
  assign result.window_done = win_ctl.close;

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || in_acc;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : result;
    end
    if (!out_free && in_acc) begin
      skid_word <= result;
    end
  end

  // checks
  `QDV_ASSERT_SAME(a_skid_implies_out, skid_valid, out_valid)
  `QDV_ASSERT_SAME(a_close_on_tick_only, win_ctl.close, in_acc && in_word.func == FUNC_TICK)
  `QDV_ASSERT_NEXT(a_held_word_spills, in_acc && !out_free, skid_valid && out_valid)
  `QDV_ASSERT_NEXT(a_taken_skid_drains, skid_valid && out_take, !skid_valid && out_valid)

endmodule
